### design/des_pkg.sv
// ----------------------------------------------------------------------------
// des_pkg : shared types, tables and round function for the DES round engine
// Holds the E, P and S-box tables, the Feistel round function and the
// controller/datapath interface types.
// ----------------------------------------------------------------------------
package des_pkg;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_HOLD
	} des_state_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic start;     // capture block and mode, clear round count
		logic step;      // do one round
		logic key_we;    // write one subkey
		logic out_load;  // load result register
		logic out_sel;   // 1: result from held halves, 0: from round output
	} des_ctl_t;

	// Status from datapath to controller
	typedef struct packed {
		logic last;      // round count is at the final round
	} des_sts_t;

	// DES bit numbering: bit 1 is the MSB
	localparam logic [5:0] E_TAB [48] = '{
		6'd32, 6'd1,  6'd2,  6'd3,  6'd4,  6'd5,  6'd4,  6'd5,  6'd6,  6'd7,  6'd8,  6'd9,
		6'd8,  6'd9,  6'd10, 6'd11, 6'd12, 6'd13, 6'd12, 6'd13, 6'd14, 6'd15, 6'd16, 6'd17,
		6'd16, 6'd17, 6'd18, 6'd19, 6'd20, 6'd21, 6'd20, 6'd21, 6'd22, 6'd23, 6'd24, 6'd25,
		6'd24, 6'd25, 6'd26, 6'd27, 6'd28, 6'd29, 6'd28, 6'd29, 6'd30, 6'd31, 6'd32, 6'd1
	};

	localparam logic [5:0] P_TAB [32] = '{
		6'd16, 6'd7,  6'd20, 6'd21, 6'd29, 6'd12, 6'd28, 6'd17,
		6'd1,  6'd15, 6'd23, 6'd26, 6'd5,  6'd18, 6'd31, 6'd10,
		6'd2,  6'd8,  6'd24, 6'd14, 6'd32, 6'd27, 6'd3,  6'd9,
		6'd19, 6'd13, 6'd30, 6'd6,  6'd22, 6'd11, 6'd4,  6'd25
	};

	localparam logic [3:0] SBOX [8][64] = '{
		'{4'd14,4'd4,4'd13,4'd1,4'd2,4'd15,4'd11,4'd8,4'd3,4'd10,4'd6,4'd12,4'd5,4'd9,4'd0,4'd7,
		  4'd0,4'd15,4'd7,4'd4,4'd14,4'd2,4'd13,4'd1,4'd10,4'd6,4'd12,4'd11,4'd9,4'd5,4'd3,4'd8,
		  4'd4,4'd1,4'd14,4'd8,4'd13,4'd6,4'd2,4'd11,4'd15,4'd12,4'd9,4'd7,4'd3,4'd10,4'd5,4'd0,
		  4'd15,4'd12,4'd8,4'd2,4'd4,4'd9,4'd1,4'd7,4'd5,4'd11,4'd3,4'd14,4'd10,4'd0,4'd6,4'd13},
		'{4'd15,4'd1,4'd8,4'd14,4'd6,4'd11,4'd3,4'd4,4'd9,4'd7,4'd2,4'd13,4'd12,4'd0,4'd5,4'd10,
		  4'd3,4'd13,4'd4,4'd7,4'd15,4'd2,4'd8,4'd14,4'd12,4'd0,4'd1,4'd10,4'd6,4'd9,4'd11,4'd5,
		  4'd0,4'd14,4'd7,4'd11,4'd10,4'd4,4'd13,4'd1,4'd5,4'd8,4'd12,4'd6,4'd9,4'd3,4'd2,4'd15,
		  4'd13,4'd8,4'd10,4'd1,4'd3,4'd15,4'd4,4'd2,4'd11,4'd6,4'd7,4'd12,4'd0,4'd5,4'd14,4'd9},
		'{4'd10,4'd0,4'd9,4'd14,4'd6,4'd3,4'd15,4'd5,4'd1,4'd13,4'd12,4'd7,4'd11,4'd4,4'd2,4'd8,
		  4'd13,4'd7,4'd0,4'd9,4'd3,4'd4,4'd6,4'd10,4'd2,4'd8,4'd5,4'd14,4'd12,4'd11,4'd15,4'd1,
		  4'd13,4'd6,4'd4,4'd9,4'd8,4'd15,4'd3,4'd0,4'd11,4'd1,4'd2,4'd12,4'd5,4'd10,4'd14,4'd7,
		  4'd1,4'd10,4'd13,4'd0,4'd6,4'd9,4'd8,4'd7,4'd4,4'd15,4'd14,4'd3,4'd11,4'd5,4'd2,4'd12},
		'{4'd7,4'd13,4'd14,4'd3,4'd0,4'd6,4'd9,4'd10,4'd1,4'd2,4'd8,4'd5,4'd11,4'd12,4'd4,4'd15,
		  4'd13,4'd8,4'd11,4'd5,4'd6,4'd15,4'd0,4'd3,4'd4,4'd7,4'd2,4'd12,4'd1,4'd10,4'd14,4'd9,
		  4'd10,4'd6,4'd9,4'd0,4'd12,4'd11,4'd7,4'd13,4'd15,4'd1,4'd3,4'd14,4'd5,4'd2,4'd8,4'd4,
		  4'd3,4'd15,4'd0,4'd6,4'd10,4'd1,4'd13,4'd8,4'd9,4'd4,4'd5,4'd11,4'd12,4'd7,4'd2,4'd14},
		'{4'd2,4'd12,4'd4,4'd1,4'd7,4'd10,4'd11,4'd6,4'd8,4'd5,4'd3,4'd15,4'd13,4'd0,4'd14,4'd9,
		  4'd14,4'd11,4'd2,4'd12,4'd4,4'd7,4'd13,4'd1,4'd5,4'd0,4'd15,4'd10,4'd3,4'd9,4'd8,4'd6,
		  4'd4,4'd2,4'd1,4'd11,4'd10,4'd13,4'd7,4'd8,4'd15,4'd9,4'd12,4'd5,4'd6,4'd3,4'd0,4'd14,
		  4'd11,4'd8,4'd12,4'd7,4'd1,4'd14,4'd2,4'd13,4'd6,4'd15,4'd0,4'd9,4'd10,4'd4,4'd5,4'd3},
		'{4'd12,4'd1,4'd10,4'd15,4'd9,4'd2,4'd6,4'd8,4'd0,4'd13,4'd3,4'd4,4'd14,4'd7,4'd5,4'd11,
		  4'd10,4'd15,4'd4,4'd2,4'd7,4'd12,4'd9,4'd5,4'd6,4'd1,4'd13,4'd14,4'd0,4'd11,4'd3,4'd8,
		  4'd9,4'd14,4'd15,4'd5,4'd2,4'd8,4'd12,4'd3,4'd7,4'd0,4'd4,4'd10,4'd1,4'd13,4'd11,4'd6,
		  4'd4,4'd3,4'd2,4'd12,4'd9,4'd5,4'd15,4'd10,4'd11,4'd14,4'd1,4'd7,4'd6,4'd0,4'd8,4'd13},
		'{4'd4,4'd11,4'd2,4'd14,4'd15,4'd0,4'd8,4'd13,4'd3,4'd12,4'd9,4'd7,4'd5,4'd10,4'd6,4'd1,
		  4'd13,4'd0,4'd11,4'd7,4'd4,4'd9,4'd1,4'd10,4'd14,4'd3,4'd5,4'd12,4'd2,4'd15,4'd8,4'd6,
		  4'd1,4'd4,4'd11,4'd13,4'd12,4'd3,4'd7,4'd14,4'd10,4'd15,4'd6,4'd8,4'd0,4'd5,4'd9,4'd2,
		  4'd6,4'd11,4'd13,4'd8,4'd1,4'd4,4'd10,4'd7,4'd9,4'd5,4'd0,4'd15,4'd14,4'd2,4'd3,4'd12},
		'{4'd13,4'd2,4'd8,4'd4,4'd6,4'd15,4'd11,4'd1,4'd10,4'd9,4'd3,4'd14,4'd5,4'd0,4'd12,4'd7,
		  4'd1,4'd15,4'd13,4'd8,4'd10,4'd3,4'd7,4'd4,4'd12,4'd5,4'd6,4'd11,4'd0,4'd14,4'd9,4'd2,
		  4'd7,4'd11,4'd4,4'd1,4'd9,4'd12,4'd14,4'd2,4'd0,4'd6,4'd10,4'd13,4'd15,4'd3,4'd5,4'd8,
		  4'd2,4'd1,4'd14,4'd7,4'd4,4'd10,4'd8,4'd13,4'd15,4'd12,4'd9,4'd0,4'd3,4'd5,4'd6,4'd11}
	};

	function automatic logic [47:0] des_expand(input logic [31:0] h);
		logic [47:0] r;
		r = '0;
		for (int k = 0; k < 48; k++) begin
			r[47-k] = h[5'(6'd32 - E_TAB[k])];
		end
		return r;
	endfunction

	function automatic logic [31:0] des_perm(input logic [31:0] s);
		logic [31:0] r;
		r = '0;
		for (int k = 0; k < 32; k++) begin
			r[31-k] = s[5'(6'd32 - P_TAB[k])];
		end
		return r;
	endfunction

	// Feistel f: E, key mix, S-boxes (S1 on the top six bits), P
	function automatic logic [31:0] des_f(input logic [31:0] half, input logic [47:0] key);
		logic [47:0] x;
		logic [5:0]  six;
		logic [31:0] s;
		x = des_expand(half) ^ key;
		s = '0;
		for (int b = 0; b < 8; b++) begin
			six = x[47-6*b -: 6];
			s[31-4*b -: 4] = SBOX[b][{six[5], six[0], six[4:1]}];
		end
		return des_perm(s);
	endfunction

endpackage

### design/des_sixteen_round_feistel.sv
// ----------------------------------------------------------------------------
// des_sixteen_round_feistel : iterative sixteen-round DES Feistel core
// Loads 48-bit subkeys into a 16-entry store and runs sixteen DES rounds on
// a block already through the initial permutation, one round per cycle.
// ----------------------------------------------------------------------------
//
//  channel | handshake            | word contents
//  --------+----------------------+------------------------------------------
//  cmd     | cmd_valid, cmd_stall | operation, key_slot, round_key,
//          |                      | data_block, decrypt_mode
//  rsp     | rsp_valid, rsp_stall | result_block
//
//  Key load words produce no response word.
//  A block word is accepted in idle and then runs sixteen rounds through
//  the single round unit; cmd stalls meanwhile, so no new word is taken.
//  The result lands in an output register at the last round; if that
//  register is still stalled, the halves are parked and cmd stalls until
//  rsp drains. Reset clears control only; subkey slots read as garbage
//  until written.
//
module des_sixteen_round_feistel import des_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cmd_valid,
	output logic        cmd_stall,
	input  logic        operation,
	input  logic [3:0]  key_slot,
	input  logic [47:0] round_key,
	input  logic [63:0] data_block,
	input  logic        decrypt_mode,
	output logic        rsp_valid,
	input  logic        rsp_stall,
	output logic [63:0] result_block
);

	des_ctl_t ctl;
	des_sts_t sts;

	// sequencer: state, handshakes, result-register valid
	des_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.operation (operation),
		.cmd_stall (cmd_stall),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.sts       (sts),
		.ctl       (ctl)
	);

	// subkey store, halves, round unit, result register
	des_dpath u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.sts          (sts),
		.key_slot     (key_slot),
		.round_key    (round_key),
		.data_block   (data_block),
		.decrypt_mode (decrypt_mode),
		.result_block (result_block)
	);

endmodule

### design/des_ctrl.sv
// ----------------------------------------------------------------------------
// des_ctrl : sequencer for the DES round engine
// Accepts words in idle, runs sixteen rounds, parks the result in the
// output register and holds the halves while that register is still full.
// ----------------------------------------------------------------------------
module des_ctrl import des_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     cmd_valid,
	input  logic     operation,
	output logic     cmd_stall,
	output logic     rsp_valid,
	input  logic     rsp_stall,
	input  des_sts_t sts,
	output des_ctl_t ctl
);

	des_state_t state_q, state_nx;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || !rsp_stall;
	assign rsp_valid = out_valid_q;

	always_comb begin
		state_nx = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid && operation) state_nx = ST_RUN;
			end
			ST_RUN: begin
				if (sts.last) state_nx = out_free ? ST_IDLE : ST_HOLD;
			end
			ST_HOLD: begin
				if (out_free) state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	always_comb begin
		ctl       = '0;
		cmd_stall = 1'b1;
		case (state_q)
			ST_IDLE: begin
				cmd_stall  = 1'b0;
				ctl.start  = cmd_valid && operation;
				ctl.key_we = cmd_valid && !operation;
			end
			ST_RUN: begin
				ctl.step     = 1'b1;
				ctl.out_load = sts.last && out_free;
			end
			ST_HOLD: begin
				ctl.out_sel  = 1'b1;
				ctl.out_load = out_free;
			end
			default: begin
				cmd_stall = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (ctl.out_load) out_valid_q <= 1'b1;
			else if (!rsp_stall) out_valid_q <= 1'b0;
		end
	end

	// result register is never overwritten while a word waits in it
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.out_load |-> !(out_valid_q && rsp_stall))
		else $error("result overwritten while stalled");

	// a new block starts at round zero, not at the final round
	a_start_round0: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.start |=> (state_q == ST_RUN) && !sts.last)
		else $error("round count not cleared at start");

	// parked halves always mean a full result register
	a_hold_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_HOLD) |-> out_valid_q)
		else $error("hold state with empty result register");

	// rounds keep going until the final round
	a_run_cont: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_RUN) && !sts.last |=> (state_q == ST_RUN))
		else $error("round sequence cut short");

endmodule

### design/des_dpath.sv
// ----------------------------------------------------------------------------
// des_dpath : round datapath for the DES round engine
// Subkey store, left/right half registers, round counter, one Feistel
// round per cycle, result register.
// ----------------------------------------------------------------------------
module des_dpath import des_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  des_ctl_t    ctl,
	output des_sts_t    sts,
	input  logic [3:0]  key_slot,
	input  logic [47:0] round_key,
	input  logic [63:0] data_block,
	input  logic        decrypt_mode,
	output logic [63:0] result_block
);

	logic [47:0] key_q [16];
	logic [31:0] l_q, r_q;
	logic [3:0]  round_q;
	logic        dec_q;
	logic [63:0] result_q;
	logic [3:0]  slot;
	logic [31:0] r_nx;

	// decrypt walks the store from the top slot down
	assign slot     = dec_q ? ~round_q : round_q;
	assign r_nx     = l_q ^ des_f(r_q, key_q[slot]);
	assign sts.last = (round_q == 4'hF);

	assign result_block = result_q;

	always_ff @(posedge clk) begin
		if (ctl.key_we) key_q[key_slot] <= round_key;
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			l_q   <= data_block[63:32];
			r_q   <= data_block[31:0];
			dec_q <= decrypt_mode;
		end else if (ctl.step) begin
			l_q <= r_q;
			r_q <= r_nx;
		end
		// output is right half then left half
		if (ctl.out_load) result_q <= ctl.out_sel ? {r_q, l_q} : {r_nx, r_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			round_q <= '0;
		end else if (ctl.start) begin
			round_q <= '0;
		end else if (ctl.step) begin
			round_q <= round_q + 4'd1;
		end
	end

endmodule
